### rtl/spq_pkg.sv
// Package for the sorted priority queue: sizes, operation and status codes,
// cell data types and width helpers. No dependencies.
package spq_pkg;

    // Store size and id counter width
    localparam int DEPTH   = 32;
    localparam int ID_BITS = 16;

    // Derived widths
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // Fixed field widths of the channels
    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RID_W    = 16;
    localparam int COUNT_W  = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [ID_BITS-1:0]        id;
    } cell_data_t;

    // Insert broadcast to every cell
    typedef struct packed {
        logic       en;
        cell_data_t data;
    } ins_cmd_t;

    // Id to the fixed 16-bit result field
    function automatic logic [RID_W-1:0] id_to_field(input logic [ID_BITS-1:0] id);
        logic [31:0] wide;
        wide = 32'(id);
        return wide[RID_W-1:0];
    endfunction

    // Occupancy to the fixed 6-bit result field
    function automatic logic [COUNT_W-1:0] cnt_to_field(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[COUNT_W-1:0];
    endfunction

endpackage

### rtl/spq_if.sv
// Handshake interfaces for the sorted priority queue request and response
// channels. Depends on spq_pkg.
interface spq_req_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [OPCODE_W-1:0]       opcode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, opcode, value, input ready);
    modport sink   (input valid, opcode, value, output ready);
endinterface

interface spq_rsp_if
    import spq_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [RID_W-1:0]          removed_id;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, status, removed_value, removed_id, entry_count,
                    input ready);
    modport sink   (input valid, status, removed_value, removed_id, entry_count,
                    output ready);
endinterface

### rtl/spq_cell.sv
// One slot of the sorted store: holds an entry, compares it with the value
// being inserted and shifts up from its lower neighbour. Depends on spq_pkg.
module spq_cell
    import spq_pkg::*;
(
    input  logic       clk,
    input  ins_cmd_t   ins,
    input  logic       valid,
    input  logic       left_mark,
    input  cell_data_t left_data,
    output logic       mark,
    output cell_data_t data
);

    cell_data_t data_reg;
    cell_data_t data_next;

    // Slot is at or above the insert point: empty, or holds a larger value
    assign mark = !valid || (data_reg.value > ins.data.value);

    // Shift from below when the neighbour also moves, else take the new entry
    always_comb
    begin
        data_next = data_reg;
        if (ins.en && mark)
        begin
            if (left_mark)
                data_next = left_data;
            else
                data_next = ins.data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/sorted_priority_queue_top.sv
// Sorted priority queue top level: row of spq_cell slots, occupancy and id
// counters, and the registered response. Depends on spq_pkg, spq_if, spq_cell.
//
//   channel | dir | fields
//   --------+-----+--------------------------------------------------
//   req     | in  | opcode, value
//   rsp     | out | status, removed_value, removed_id, entry_count
//
// All slots compare against the new value at once and shift on the edge that
// takes the beat; the response appears the cycle after.
// A new beat is taken while the response register is empty or being drained,
// so one beat per cycle runs with rsp.ready held high.
// rst_n clears occupancy, the id counter and the response valid; slot
// contents are not reset.
module sorted_priority_queue_top
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spq_req_if.sink   req,
    spq_rsp_if.source rsp
);

    logic [CNT_W-1:0]   occ_reg,  occ_next;
    logic [ID_BITS-1:0] seq_reg,  seq_next;
    logic               rsp_valid_reg;
    status_t            status_reg,  status_next;
    logic signed [VALUE_W-1:0] rval_reg, rval_next;
    logic [RID_W-1:0]   rid_reg,  rid_next;
    logic [COUNT_W-1:0] cnt_reg;

    logic       accept;
    logic       full;
    logic       empty;
    ins_cmd_t   ins;
    logic [IDX_W-1:0] top_idx;

    logic       cell_valid [DEPTH];
    logic       cell_mark  [DEPTH];
    cell_data_t cell_data  [DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (occ_reg == CNT_W'(DEPTH));
    assign empty     = (occ_reg == '0);
    assign top_idx   = IDX_W'(occ_reg - CNT_W'(1));

    // Insert broadcast
    always_comb
    begin
        ins.en         = accept && (opcode_t'(req.opcode) == OP_INSERT) && !full;
        ins.data.value = req.value;
        ins.data.id    = seq_reg;
    end

    // Row of slots, slot 0 holds the smallest value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_valid[i] = (occ_reg > CNT_W'(i));
        if (i == 0)
        begin : g_first
            spq_cell u_cell (
                .clk       (clk),
                .ins       (ins),
                .valid     (cell_valid[i]),
                .left_mark (1'b0),
                .left_data (cell_data[i]),
                .mark      (cell_mark[i]),
                .data      (cell_data[i])
            );
        end
        else
        begin : g_next
            spq_cell u_cell (
                .clk       (clk),
                .ins       (ins),
                .valid     (cell_valid[i]),
                .left_mark (cell_mark[i-1]),
                .left_data (cell_data[i-1]),
                .mark      (cell_mark[i]),
                .data      (cell_data[i])
            );
        end
    end

    // Counters and response contents for the beat taken now
    always_comb
    begin
        occ_next    = occ_reg;
        seq_next    = seq_reg;
        status_next = ST_OK;
        rval_next   = '0;
        rid_next    = '0;
        case (opcode_t'(req.opcode))
            OP_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
                else
                begin
                    occ_next = occ_reg + CNT_W'(1);
                    seq_next = seq_reg + ID_BITS'(1);
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    occ_next  = occ_reg - CNT_W'(1);
                    rval_next = cell_data[top_idx].value;
                    rid_next  = id_to_field(cell_data[top_idx].id);
                end
            end
            OP_CLEAR:
            begin
                occ_next = '0;
            end
            default:
            begin
                occ_next = occ_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            seq_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg <= occ_next;
                seq_reg <= seq_next;
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rval_reg   <= rval_next;
            rid_reg    <= rid_next;
            cnt_reg    <= cnt_to_field(occ_next);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.removed_value = rval_reg;
    assign rsp.removed_id    = rid_reg;
    assign rsp.entry_count   = cnt_reg;

endmodule

### test/testbench.sv
// Self-checking testbench for sorted_priority_queue_top: directed and random insert, remove and
// clear beats, with a scoreboard class that tracks the sorted store and the id counter.
// Depends on spq_pkg, spq_if and the queue RTL.
`timescale 1ns / 100ps

module testbench
    import spq_pkg::*;
;
    localparam int  RANDOM_ITEMS = 1750;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  REPORT_MAX   = 10;
    localparam int  DRAIN_CYCLES = 8;

    // One response beat as seen on the rsp channel
    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [RID_W-1:0]          removed_id;
        logic [COUNT_W-1:0]        entry_count;
    } pq_result_t;

    // Scoreboard: own copy of the sorted store, fed by accepted requests
    class pq_scoreboard;
        logic signed [VALUE_W-1:0] slot_value [DEPTH];
        logic [ID_BITS-1:0]        slot_id    [DEPTH];
        int                        held;
        logic [ID_BITS-1:0]        id_counter;
        pq_result_t                awaited_responses [$];
        int                        failures;

        function new();
            held       = 0;
            id_counter = '0;
            failures   = 0;
        endfunction

        // Work out the response of one operation and update the store
        function pq_result_t apply_queue_op(input logic [OPCODE_W-1:0] op,
                                            input logic signed [VALUE_W-1:0] val);
            pq_result_t r;
            int         pos;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_INSERT:
                begin
                    if (held >= DEPTH)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        // new value goes after all equal or smaller values
                        pos = 0;
                        while (pos < held && slot_value[pos] <= val)
                            pos++;
                        for (int k = held; k > pos; k--)
                        begin
                            slot_value[k] = slot_value[k-1];
                            slot_id[k]    = slot_id[k-1];
                        end
                        slot_value[pos] = val;
                        slot_id[pos]    = id_counter;
                        id_counter++;
                        held++;
                    end
                end
                OP_REMOVE:
                begin
                    if (held == 0)
                    begin
                        r.status = ST_EMPTY;
                    end
                    else
                    begin
                        held--;
                        r.removed_value = slot_value[held];
                        r.removed_id    = RID_W'(slot_id[held]);
                    end
                end
                OP_CLEAR:
                begin
                    held = 0;
                end
                default:
                begin
                end
            endcase
            r.entry_count = COUNT_W'(held);
            return r;
        endfunction

        function void record_request(input logic [OPCODE_W-1:0] op,
                                     input logic signed [VALUE_W-1:0] val);
            awaited_responses.push_back(apply_queue_op(op, val));
        endfunction

        function void check_response(input pq_result_t got);
            pq_result_t want;
            logic       bad;
            if (awaited_responses.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected response beat: status=%0d value=%0d id=%0d count=%0d",
                             got.status, got.removed_value, got.removed_id, got.entry_count);
                return;
            end
            want = awaited_responses.pop_front();
            bad  = (got.status !== want.status) ||
                   (got.removed_value !== want.removed_value) ||
                   (got.removed_id !== want.removed_id) ||
                   (got.entry_count !== want.entry_count);
            if (bad)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch: expected status=%0d value=%0d id=%0d count=%0d, got status=%0d value=%0d id=%0d count=%0d",
                             want.status, want.removed_value, want.removed_id,
                             want.entry_count, got.status, got.removed_value,
                             got.removed_id, got.entry_count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_off;
    int   sent_total;
    int   burst_left;
    int   cycle_count;

    pq_scoreboard sb = new();

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Watch accepted beats on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response({rsp_ch.status, rsp_ch.removed_value,
                                   rsp_ch.removed_id, rsp_ch.entry_count});
            if (req_ch.valid && req_ch.ready)
                sb.record_request(req_ch.opcode, req_ch.value);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Receiver: stretches of always-ready, a rotating stall pattern or random stalls
    initial
    begin : receiver
        int          stretch;
        int          mode;
        logic [15:0] pattern;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(20, 300);
            pattern = 16'($urandom) | 16'h0001;
            repeat (stretch)
            begin
                @(posedge clk);
                case (mode)
                    0: rsp_ch.ready <= !hold_off;
                    1:
                    begin
                        rsp_ch.ready <= !hold_off && pattern[0];
                        pattern = {pattern[0], pattern[15:1]};
                    end
                    2: rsp_ch.ready <= !hold_off && ($urandom_range(0, 3) != 0);
                    default: rsp_ch.ready <= !hold_off && ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Long receiver hold-offs while the sender keeps offering beats
    initial
    begin : pressure
        hold_off <= 1'b0;
        wait (sent_total >= 400);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        wait (sent_total >= 1200);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one beat, opening a new burst after a random gap when the last one ran out
    task automatic send_beat(input opcode_t op, input logic signed [VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 2);
                2: gap = $urandom_range(1, 6);
                default: gap = $urandom_range(5, 20);
            endcase
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.value  <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sent_total++;
    endtask

    // Value picker: full range, tight cluster for ties, extremes, or a moderate spread
    function automatic logic signed [VALUE_W-1:0] pick_value(input int mode);
        logic signed [VALUE_W-1:0] v;
        case (mode)
            0: v = $urandom;
            1: v = int'($urandom_range(0, 6)) - 3;
            2:
            begin
                case ($urandom_range(0, 6))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 32'sh8000_0001;
                    3: v = 32'sh7fff_fffe;
                    4: v = 0;
                    5: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = int'($urandom_range(0, 2000)) - 1000;
        endcase
        return v;
    endfunction

    // Stimulus
    initial
    begin : stimulus
        int seq_kind;
        int vmode;
        int n;
        int directed_total;

        rst_n          = 1'b0;
        sent_total     = 0;
        burst_left     = 0;
        cycle_count    = 0;
        req_ch.valid  <= 1'b0;
        req_ch.opcode <= OP_INSERT;
        req_ch.value  <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, extremes, ties, clear, fill to full
        send_beat(OP_REMOVE, $urandom);
        send_beat(OP_CLEAR, $urandom);
        send_beat(OP_INSERT, 32'sh7fff_ffff);
        send_beat(OP_INSERT, 32'sh8000_0000);
        send_beat(OP_INSERT, 0);
        send_beat(OP_INSERT, 5);
        send_beat(OP_INSERT, 5);
        send_beat(OP_INSERT, 5);
        send_beat(OP_INSERT, -1);
        repeat (5) send_beat(OP_REMOVE, $urandom);
        send_beat(OP_CLEAR, $urandom);
        send_beat(OP_REMOVE, 32'sh7fff_ffff);
        // fill beyond capacity: last insert dropped as full
        for (int i = 0; i <= DEPTH; i++)
            send_beat(OP_INSERT, int'($urandom_range(0, 4)) - 2);
        send_beat(OP_REMOVE, $urandom);
        send_beat(OP_INSERT, 32'sh8000_0000);
        send_beat(OP_INSERT, 32'sh7fff_ffff);
        send_beat(OP_CLEAR, $urandom);
        directed_total = sent_total;

        // Random sequences
        while (sent_total - directed_total < RANDOM_ITEMS)
        begin
            seq_kind = $urandom_range(0, 9);
            vmode    = $urandom_range(0, 3);
            if (seq_kind <= 2)
            begin
                // fill then drain, sometimes past full or past empty
                n = $urandom_range(1, DEPTH + 4);
                repeat (n) send_beat(OP_INSERT, pick_value(vmode));
                repeat ($urandom_range(1, n + 2)) send_beat(OP_REMOVE, $urandom);
            end
            else if (seq_kind <= 6)
            begin
                // mixed operations
                repeat ($urandom_range(10, 60))
                begin
                    n = $urandom_range(0, 19);
                    if (n < 10)
                        send_beat(OP_INSERT, pick_value(vmode));
                    else if (n < 19)
                        send_beat(OP_REMOVE, $urandom);
                    else
                        send_beat(OP_CLEAR, $urandom);
                end
            end
            else if (seq_kind <= 8)
            begin
                // ties: interleaved inserts and removes on a tight cluster
                repeat ($urandom_range(10, 40))
                begin
                    if ($urandom_range(0, 2) != 0)
                        send_beat(OP_INSERT, pick_value(1));
                    else
                        send_beat(OP_REMOVE, $urandom);
                end
            end
            else
            begin
                // clear then hit the empty store
                send_beat(OP_CLEAR, $urandom);
                repeat ($urandom_range(1, 3)) send_beat(OP_REMOVE, $urandom);
            end
        end

        // Drain and finish
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited_responses.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.awaited_responses.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
